[design/rdc_pkg.sv]
package rdc_pkg;

    localparam int COUNT_WIDTH     = 20;
    localparam int OUT_COUNT_WIDTH = 20;
    localparam int PIX_WIDTH       = 16;
    localparam int CHAN_WIDTH      = 8;

    // Wide enough to hold the counter and the output count field
    localparam int COUNT_EXT_WIDTH =
        (COUNT_WIDTH > OUT_COUNT_WIDTH) ? COUNT_WIDTH : OUT_COUNT_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // RGB565 field positions
    localparam int RED_LSB   = 11;
    localparam int GREEN_LSB = 5;

    typedef logic [PIX_WIDTH-1:0]  t_pixel;
    typedef logic [CHAN_WIDTH-1:0] t_chan;

    typedef struct packed {
        t_pixel with_pixel;
        t_pixel without_pixel;
        t_pixel reflect_pixel;
        logic   first_pixel;
    } t_in_item;

    typedef struct packed {
        t_pixel                     out_pixel;
        logic                       in_mask;
        logic [OUT_COUNT_WIDTH-1:0] mask_count;
    } t_out_item;

    // Counter control for one pixel moving into the result register
    typedef struct packed {
        logic advance;
        logic first;
        logic mask;
    } t_cnt_ctl;

    // Channel widening tables: value*255/max, truncated
    typedef t_chan t_tab5 [32];
    typedef t_chan t_tab6 [64];

    function automatic t_tab5 f_build_tab5();
        t_tab5 t;
        for (int i = 0; i < 32; i++) begin
            t[i] = CHAN_WIDTH'(i * 255 / 31);
        end
        return t;
    endfunction

    function automatic t_tab6 f_build_tab6();
        t_tab6 t;
        for (int i = 0; i < 64; i++) begin
            t[i] = CHAN_WIDTH'(i * 255 / 63);
        end
        return t;
    endfunction

    localparam t_tab5 WIDEN5 = f_build_tab5();
    localparam t_tab6 WIDEN6 = f_build_tab6();

endpackage

[design/rdc_if.sv]
interface rdc_in_if import rdc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/rdc_pixel_calc.sv]
module rdc_pixel_calc import rdc_pkg::*; (
    input  t_pixel i_with,
    input  t_pixel i_without,
    input  t_pixel i_reflect,
    output t_pixel o_pixel,
    output logic   o_mask
);

    // with - without + reflect, clamped to 0..255
    function automatic t_chan f_mix(t_chan a, t_chan b, t_chan c);
        logic signed [CHAN_WIDTH+1:0] v;
        v = $signed({2'b00, a}) - $signed({2'b00, b}) + $signed({2'b00, c});
        if (v < 0) begin
            return '0;
        end else if (v > 255) begin
            return '1;
        end
        return v[CHAN_WIDTH-1:0];
    endfunction

    t_chan w_r, w_g, w_b;
    t_chan wo_r, wo_g, wo_b;
    t_chan rf_r, rf_g, rf_b;
    t_chan c_r, c_g, c_b;

    always_comb begin
        w_r  = WIDEN5[i_with[15:11]];
        w_g  = WIDEN6[i_with[10:5]];
        w_b  = WIDEN5[i_with[4:0]];
        wo_r = WIDEN5[i_without[15:11]];
        wo_g = WIDEN6[i_without[10:5]];
        wo_b = WIDEN5[i_without[4:0]];
        rf_r = WIDEN5[i_reflect[15:11]];
        rf_g = WIDEN6[i_reflect[10:5]];
        rf_b = WIDEN5[i_reflect[4:0]];

        c_r = f_mix(w_r, wo_r, rf_r);
        c_g = f_mix(w_g, wo_g, rf_g);
        c_b = f_mix(w_b, wo_b, rf_b);

        o_mask = (i_with != i_without);
        if (o_mask) begin
            o_pixel = (t_pixel'(c_r[7:3]) << RED_LSB)
                    | (t_pixel'(c_g[7:2]) << GREEN_LSB)
                    | t_pixel'(c_b[7:3]);
        end else begin
            o_pixel = i_with;
        end
    end

endmodule

[design/rdc_mask_counter.sv]
module rdc_mask_counter import rdc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cnt_ctl               i_ctl,
    output logic [COUNT_WIDTH-1:0] o_count
);

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] base;

    // o_count is the value after this pixel, as carried with its result
    always_comb begin
        base = i_ctl.first ? '0 : r_count;
        if (i_ctl.mask && (base != COUNT_MAX)) begin
            n_count = base + COUNT_WIDTH'(1);
        end else begin
            n_count = base;
        end
        o_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.advance) begin
            r_count <= n_count;
        end
    end

endmodule

[design/rgb565_difference_composite_top.sv]
// RGB565 mirror composite. Each transfer on i_pix carries one pixel position:
// the frame drawn with the mirror, the same frame without it, and the reflected
// view. Where the with and without pixels match, the with pixel passes through.
// Otherwise each channel is widened to 8 bits (value*255/max, truncated), the
// block forms with - without + reflect per channel, clamps to 0..255, repacks
// to RGB565 by truncation and flags the pixel as a mask pixel. first_pixel
// clears the per-frame mask count before the pixel is counted; the count
// saturates at its maximum. One result transfer leaves o_res for every input
// transfer, in order. Throughput is one pixel per clock while the sink is
// ready. Each result passes the input register, then the result register,
// before it is offered on o_res. Both registers keep moving while the sink
// holds ready high.
module rgb565_difference_composite_top import rdc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rdc_in_if.sink    i_pix,
    rdc_out_if.source o_res
);

    // Input register stage
    logic     r_s1_valid;
    t_in_item r_s1_data;

    // Result register stage
    logic      r_s2_valid;
    t_out_item r_s2_data;

    logic s1_ready;
    logic s2_ready;
    logic advance;

    t_pixel                     calc_pixel;
    logic                       calc_mask;
    logic [COUNT_WIDTH-1:0]     cnt_value;
    logic [COUNT_EXT_WIDTH-1:0] cnt_ext;
    t_cnt_ctl                   cnt_ctl;

    // Each stage takes new data when empty or when its content moves on
    assign s2_ready    = !r_s2_valid || o_res.ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign advance     = r_s1_valid && s2_ready;
    assign i_pix.ready = s1_ready;

    assign o_res.valid = r_s2_valid;
    assign o_res.data  = r_s2_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_pix.valid) begin
            r_s1_data <= i_pix.data;
        end
    end

    rdc_pixel_calc u_calc (
        .i_with    (r_s1_data.with_pixel),
        .i_without (r_s1_data.without_pixel),
        .i_reflect (r_s1_data.reflect_pixel),
        .o_pixel   (calc_pixel),
        .o_mask    (calc_mask)
    );

    // Counter steps only when the pixel actually moves into the result stage
    always_comb begin
        cnt_ctl.advance = advance;
        cnt_ctl.first   = r_s1_data.first_pixel;
        cnt_ctl.mask    = calc_mask;
    end

    rdc_mask_counter u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cnt_ctl),
        .o_count (cnt_value)
    );

    // Zero extend, then keep the low bits of the output field
    assign cnt_ext = COUNT_EXT_WIDTH'(cnt_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_data.out_pixel  <= calc_pixel;
            r_s2_data.in_mask    <= calc_mask;
            r_s2_data.mask_count <= cnt_ext[OUT_COUNT_WIDTH-1:0];
        end
    end

endmodule

[sim/tb.sv]
module tb;
    import rdc_pkg::*;

    localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no transfer on either side
    localparam int unsigned LONG_HOLD    = 300;   // result side hold-off, fills the pipe
    localparam int unsigned TOTAL_ITEMS  = 1850;
    localparam int unsigned TAIL_ITEMS   = 120;   // mask frame at the end, no idling
    localparam int unsigned DRAIN_CYCLES = 16;

    // One stimulus row: the pixel position, and optionally a hand-typed result
    typedef struct {
        t_in_item  px;
        bit        typed;
        t_out_item want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rdc_in_if  pix_if ();
    rdc_out_if res_if ();

    rgb565_difference_composite_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if.sink),
        .o_res   (res_if.source)
    );

    // Predictor state: mask pixels seen in the current frame
    logic [COUNT_WIDTH-1:0] frame_masks;

    t_row        pixels_offered[$];    // driven on i_pix, transfer still to come
    t_row        directed_rows[$];
    t_out_item   composites_due[$];    // expected results, oldest first

    int unsigned quiet_cycles   = 0;
    int unsigned fail_count     = 0;
    bit          feed_gaps_on   = 1'b0;
    bit          sink_stalls_on = 1'b0;
    bit          hold_request   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------------
    // Predictor
    // -------------------------------------------------------------------------

    // Channel k (0 red, 1 green, 2 blue) stretched to 8 bits, truncating.
    function automatic int widened(t_pixel p, int k);
        case (k)
            0:       return int'(p[RED_LSB +: 5]) * 255 / 31;
            1:       return int'(p[GREEN_LSB +: 6]) * 255 / 63;
            default: return int'(p[4:0]) * 255 / 31;
        endcase
    endfunction

    // Composite one pixel position and advance the per-frame mask count.
    function automatic t_out_item composite_pixel(t_in_item px);
        t_out_item  r;
        int         sum;
        logic [7:0] c [3];

        if (px.first_pixel) frame_masks = '0;

        r.out_pixel = px.with_pixel;
        r.in_mask   = 1'b0;
        if (px.with_pixel != px.without_pixel) begin
            for (int k = 0; k < 3; k++) begin
                sum = widened(px.with_pixel, k) - widened(px.without_pixel, k)
                    + widened(px.reflect_pixel, k);
                if (sum < 0)   sum = 0;
                if (sum > 255) sum = 255;
                c[k] = 8'(sum);
            end
            // repack by dropping low bits
            r.out_pixel = {c[0][7:3], c[1][7:2], c[2][7:3]};
            r.in_mask   = 1'b1;
            if (frame_masks != COUNT_MAX) frame_masks = frame_masks + 1'b1;
        end
        r.mask_count = OUT_COUNT_WIDTH'(COUNT_EXT_WIDTH'(frame_masks));
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // Monitor: predict on each input transfer, check on each result transfer
    // -------------------------------------------------------------------------

    task automatic report_field(string name, longint unsigned want, longint unsigned got);
        fail_count++;
        $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin
        t_row      row;
        t_out_item want;
        t_out_item got;

        if (!i_rst_n) begin
            frame_masks = '0;
        end else begin
            quiet_cycles++;
            if (pix_if.valid && pix_if.ready) begin
                quiet_cycles = 0;
                row  = pixels_offered.pop_front();
                want = composite_pixel(row.px);
                // typed rows are held to the hand-written value, predictor still advances
                composites_due = {composites_due, (row.typed ? row.want : want)};
            end
            if (res_if.valid && res_if.ready) begin
                quiet_cycles = 0;
                got = res_if.data;
                if (composites_due.size() == 0) begin
                    report_field("unexpected result, out_pixel", 0, got.out_pixel);
                end else begin
                    want = composites_due.pop_front();
                    if (got.out_pixel !== want.out_pixel)
                        report_field("out_pixel", want.out_pixel, got.out_pixel);
                    if (got.in_mask !== want.in_mask)
                        report_field("in_mask", want.in_mask, got.in_mask);
                    if (got.mask_count !== want.mask_count)
                        report_field("mask_count", want.mask_count, got.mask_count);
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold-off on request.
    // One assignment to ready per clock.
    // -------------------------------------------------------------------------
    initial begin
        int unsigned stall_left;

        stall_left   = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left != 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (sink_stalls_on && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 13);
            end
        end
    end

    // -------------------------------------------------------------------------
    // Pixel side
    // -------------------------------------------------------------------------

    // Offer one pixel position and hold it until the transfer. valid stays high
    // between back-to-back rows, so it is never dropped and raised in one step.
    task automatic send_row(t_row row);
        int unsigned gap;

        if (feed_gaps_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= row.px;
        pixels_offered = {pixels_offered, row};
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    task automatic add_row(t_pixel w, t_pixel wo, t_pixel rf, logic first,
                           bit typed, t_pixel out_px, logic mask, int unsigned cnt);
        t_row row;

        row.px.with_pixel    = w;
        row.px.without_pixel = wo;
        row.px.reflect_pixel = rf;
        row.px.first_pixel   = first;
        row.typed            = typed;
        row.want.out_pixel   = out_px;
        row.want.in_mask     = mask;
        row.want.mask_count  = OUT_COUNT_WIDTH'(cnt);
        directed_rows = {directed_rows, row};
    endtask

    // Random pixel position: mostly differing pairs, a good share of equal pairs,
    // near misses (one bit apart) and full complements.
    function automatic t_in_item random_pixel(logic first);
        t_in_item px;

        px.with_pixel    = t_pixel'($urandom);
        px.reflect_pixel = t_pixel'($urandom);
        px.first_pixel   = first;
        case ($urandom_range(0, 7))
            0, 1:    px.without_pixel = px.with_pixel;
            2:       px.without_pixel = px.with_pixel ^ (t_pixel'(1) << $urandom_range(0, 15));
            3:       px.without_pixel = ~px.with_pixel;
            default: px.without_pixel = t_pixel'($urandom);
        endcase
        if ($urandom_range(0, 15) == 0)
            px.reflect_pixel = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return px;
    endfunction

    initial begin
        t_row            row;
        int unsigned     sent;
        int unsigned     frame_left;
        logic            first;

        i_rst_n      = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: extremes, clamps both ways, pass-through, first-pixel clear
        //       with      without   reflect   first typed  out       mask  count
        add_row(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 0); // after reset
        add_row(16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1);
        add_row(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1, 2); // clamp low
        add_row(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b1, 3); // clamp high
        add_row(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 16'h0000, 1'b1, 4);
        add_row(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b0, 4); // equal pair
        add_row(16'h0000, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b0, 0); // first, unmasked
        add_row(16'hF800, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'hF800, 1'b1, 1); // red only
        add_row(16'h07E0, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h07E0, 1'b1, 2); // green only
        add_row(16'h001F, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h001F, 1'b1, 3); // blue only
        add_row(16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0001, 1'b1, 1); // first, masked
        add_row(16'h0000, 16'h0001, 16'hFFFF, 1'b0, 1'b0, '0, 1'b0, 0);
        add_row(16'h8410, 16'h4208, 16'h2104, 1'b0, 1'b0, '0, 1'b0, 0);
        add_row(16'h1234, 16'h4321, 16'hABCD, 1'b0, 1'b0, '0, 1'b0, 0);
        add_row(16'h7BEF, 16'h7BEE, 16'h0000, 1'b0, 1'b0, '0, 1'b0, 0);
        add_row(16'h0020, 16'h0000, 16'h07C0, 1'b0, 1'b0, '0, 1'b0, 0);
        add_row(16'h5555, 16'h5555, 16'hAAAA, 1'b0, 1'b0, '0, 1'b0, 0);
        add_row(16'hAAAA, 16'h5555, 16'hFFFF, 1'b1, 1'b0, '0, 1'b0, 0);

        feed_gaps_on   = 1'b1;
        sink_stalls_on = 1'b1;
        foreach (directed_rows[i]) send_row(directed_rows[i]);

        // Random frames: first_pixel opens each frame, with a stray one now and then.
        // Idling on each side is switched per segment so quiet stretches occur too.
        sent       = directed_rows.size();
        frame_left = 0;
        row.typed  = 1'b0;
        row.want   = '0;
        while (sent + TAIL_ITEMS + 4 < TOTAL_ITEMS) begin
            if (sent % 150 == 0) begin
                feed_gaps_on   = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (sent == 700) begin
                // hold the result side while pixels keep coming, so input backs up
                feed_gaps_on = 1'b0;
                hold_request = 1'b1;
            end
            first = (frame_left == 0) || ($urandom_range(0, 63) == 0);
            if (frame_left == 0) frame_left = $urandom_range(1, 60);
            frame_left--;
            row.px = random_pixel(first);
            send_row(row);
            sent++;
        end

        // Last part, no idling: one frame of mask pixels back to back, then a
        // first pixel must bring the count back down.
        feed_gaps_on   = 1'b0;
        sink_stalls_on = 1'b0;
        for (int n = 0; n < TAIL_ITEMS; n++) begin
            row.px = random_pixel(n == 0);
            if (row.px.without_pixel == row.px.with_pixel)
                row.px.without_pixel = row.px.with_pixel ^ t_pixel'($urandom_range(1, 16'hFFFF));
            send_row(row);
        end
        for (int n = 0; n < 4; n++) begin
            row.px = random_pixel(n == 0);
            send_row(row);
        end

        pix_if.valid <= 1'b0;
        while (composites_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("rgb565_difference_composite_top: match");
        end else begin
            $display("rgb565_difference_composite_top: mismatch");
        end
        $finish;
    end

    // Watchdog: too long without any transfer means the block has hung
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("rgb565_difference_composite_top: mismatch");
        $finish;
    end

endmodule
